>>> rtl/task_ready_queue_with_wait_lists_unit_assert.svh
// Assertion macros for the task ready queue unit.
`ifndef TASK_READY_QUEUE_WITH_WAIT_LISTS_UNIT_ASSERT_SVH
`define TASK_READY_QUEUE_WITH_WAIT_LISTS_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TRQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define TRQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define TRQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TRQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/trq_pkg.sv
// Shared types and constants for the task ready queue unit.
package trq_pkg;
	localparam int TaskCount = 64;
	localparam int WaitSlots = 256;
	localparam int TW = $clog2(TaskCount);
	localparam int NW = $clog2(WaitSlots);

	localparam logic [1:0] ACT_ENQ = 2'd0;
	localparam logic [1:0] ACT_BLOCK = 2'd1;
	localparam logic [1:0] ACT_DEQ = 2'd2;
	localparam logic [1:0] ACT_DONE = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_QUEUED = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	typedef struct packed {
		logic [1:0] action;
		logic [5:0] task_req;
		logic [5:0] waiter;
	} in_item_t;

	typedef struct packed {
		logic [5:0] task_out;
		logic has_task;
		logic [1:0] status;
		logic [6:0] released;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic clear_step;
		logic load;
		logic rd_list;
		logic walk_rd;
		logic walk_step;
		logic finish;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clear_done;
		logic present;
		logic last;
	} sts_t;
endpackage

>>> rtl/trq_ctrl.sv
// Sequencing controller of the task ready queue unit.
`include "task_ready_queue_with_wait_lists_unit_assert.svh"
module trq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [1:0]       action,
	input  logic             out_busy,
	input  trq_pkg::sts_t    sts,
	output logic             in_stall,
	output trq_pkg::cmd_t    cmd
);
	typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_LOOK, S_WRD, S_WSTEP, S_OUT} state_t;
	state_t state_q;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_CLEAR: cmd.clear_step = 1'b1;
			S_IDLE: cmd.load = in_valid;
			S_LOOK: begin
				cmd.rd_list = 1'b1;
			end
			S_WRD: cmd.walk_rd = 1'b1;
			S_WSTEP: cmd.walk_step = 1'b1;
			S_OUT: begin
				cmd.finish = !out_busy;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			unique case (state_q)
				S_CLEAR: if (sts.clear_done) state_q <= S_IDLE;
				S_IDLE: if (in_valid) state_q <= S_LOOK;
				S_LOOK: state_q <= (action == trq_pkg::ACT_DONE && sts.present) ? S_WRD : S_OUT;
				S_WRD: state_q <= S_WSTEP;
				S_WSTEP: state_q <= sts.last ? S_OUT : S_WRD;
				S_OUT: if (!out_busy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`TRQ_ASSERT_IMP(a_stall_busy, clk, arst_n, state_q != S_IDLE, in_stall)
	`TRQ_ASSERT_NXT(a_load_look, clk, arst_n, cmd.load, state_q == S_LOOK)
	`TRQ_ASSERT_NXT(a_walk_pair, clk, arst_n, cmd.walk_rd, cmd.walk_step)
endmodule

>>> rtl/trq_dp.sv
// Datapath of the task ready queue unit: queue, flags, lists and node pool.
`include "task_ready_queue_with_wait_lists_unit_assert.svh"
module trq_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  trq_pkg::in_item_t    in_item,
	input  trq_pkg::cmd_t        cmd,
	output trq_pkg::sts_t        sts,
	output logic [1:0]           act,
	output logic                 out_valid,
	input  logic                 out_stall,
	output trq_pkg::out_item_t   out_item
);
	localparam int TW = trq_pkg::TW;
	localparam int NW = trq_pkg::NW;

	logic [TW-1:0] fifo_mem [trq_pkg::TaskCount];
	logic [TW-1:0] node_task_mem [trq_pkg::WaitSlots];
	logic [NW-1:0] node_next_mem [trq_pkg::WaitSlots];
	logic [NW-1:0] free_mem [trq_pkg::WaitSlots];
	logic [NW-1:0] head_mem [trq_pkg::TaskCount];
	logic [NW-1:0] tail_mem [trq_pkg::TaskCount];

	logic [trq_pkg::TaskCount-1:0] queued_q, present_q;
	logic [TW-1:0] fifo_head_q;
	logic [TW:0] fifo_count_q;
	logic [NW:0] free_count_q;
	logic [NW:0] clr_q;
	logic [1:0] act_q;
	logic [TW-1:0] t_q, w_q;
	logic [NW-1:0] tail_q, node_q, fnode_q;
	logic [TW-1:0] ntask_q, fifo_rd_q;
	logic [NW-1:0] nnext_q;
	logic [6:0] rel_q;
	logic [1:0] status_q;
	logic has_q;
	logic [TW-1:0] tout_q;
	logic ovalid_q;
	trq_pkg::out_item_t out_q;
	logic deq_hit;

	logic [TW-1:0] tail_idx;
	assign tail_idx = fifo_head_q + fifo_count_q[TW-1:0];

	assign act = act_q;
	assign sts.clear_done = clr_q[NW];
	assign sts.present = present_q[t_q];
	assign sts.last = (node_q == tail_q);
	assign out_valid = ovalid_q;
	assign out_item = out_q;
	assign deq_hit = cmd.rd_list && act_q == trq_pkg::ACT_DEQ && fifo_count_q != '0;

	// memories
	always_ff @(posedge clk) begin
		if (cmd.clear_step) free_mem[clr_q[NW-1:0]] <= clr_q[NW-1:0];
		if (cmd.load) begin
			fifo_rd_q <= fifo_mem[fifo_head_q];
			fnode_q <= free_mem[free_count_q[NW-1:0] - NW'(1)];
			node_q <= head_mem[in_item.task_req];
			tail_q <= tail_mem[in_item.task_req];
		end
		if (cmd.walk_rd) begin
			ntask_q <= node_task_mem[node_q];
			nnext_q <= node_next_mem[node_q];
		end
		if (cmd.rd_list && act_q == trq_pkg::ACT_BLOCK && free_count_q != '0) begin
			node_task_mem[fnode_q] <= w_q;
			node_next_mem[fnode_q] <= fnode_q;
			if (present_q[t_q]) node_next_mem[tail_q] <= fnode_q;
			else head_mem[t_q] <= fnode_q;
			tail_mem[t_q] <= fnode_q;
		end
		if (cmd.rd_list && act_q == trq_pkg::ACT_ENQ && !queued_q[t_q])
			fifo_mem[tail_idx] <= t_q;
		if (cmd.walk_step) begin
			if (!queued_q[ntask_q]) fifo_mem[tail_idx] <= ntask_q;
			free_mem[free_count_q[NW-1:0]] <= node_q;
			node_q <= nnext_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queued_q <= '0;
			present_q <= '0;
			fifo_head_q <= '0;
			fifo_count_q <= '0;
			free_count_q <= (NW+1)'(trq_pkg::WaitSlots);
			clr_q <= '0;
			ovalid_q <= 1'b0;
			act_q <= '0;
			t_q <= '0;
			w_q <= '0;
			rel_q <= '0;
			status_q <= trq_pkg::ST_OK;
			has_q <= 1'b0;
			tout_q <= '0;
			out_q <= '0;
		end else begin
			if (cmd.clear_step) clr_q <= clr_q + 1'b1;
			if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
			if (cmd.load) begin
				act_q <= in_item.action;
				t_q <= in_item.task_req;
				w_q <= in_item.waiter;
				rel_q <= '0;
				status_q <= trq_pkg::ST_OK;
				has_q <= 1'b0;
				tout_q <= '0;
			end
			if (cmd.rd_list) begin
				unique case (act_q)
					trq_pkg::ACT_ENQ: begin
						if (queued_q[t_q]) status_q <= trq_pkg::ST_QUEUED;
						else begin
							queued_q[t_q] <= 1'b1;
							fifo_count_q <= fifo_count_q + 1'b1;
						end
					end
					trq_pkg::ACT_BLOCK: begin
						if (free_count_q == '0) status_q <= trq_pkg::ST_FULL;
						else begin
							free_count_q <= free_count_q - 1'b1;
							present_q[t_q] <= 1'b1;
						end
					end
					trq_pkg::ACT_DEQ: begin
						if (fifo_count_q == '0) status_q <= trq_pkg::ST_EMPTY;
						else begin
							fifo_head_q <= fifo_head_q + 1'b1;
							fifo_count_q <= fifo_count_q - 1'b1;
							queued_q[fifo_rd_q] <= 1'b0;
							tout_q <= fifo_rd_q;
							has_q <= 1'b1;
						end
					end
					trq_pkg::ACT_DONE: begin
						present_q[t_q] <= 1'b0;
					end
					default: ;
				endcase
			end
			if (cmd.walk_step) begin
				if (!queued_q[ntask_q]) begin
					queued_q[ntask_q] <= 1'b1;
					fifo_count_q <= fifo_count_q + 1'b1;
					rel_q <= rel_q + 1'b1;
				end
				free_count_q <= free_count_q + 1'b1;
			end
			if (cmd.finish) begin
				ovalid_q <= 1'b1;
				out_q <= '{task_out: tout_q, has_task: has_q, status: status_q,
					released: rel_q};
			end
		end
	end

	`TRQ_ASSERT_IMP(a_count_rng, clk, arst_n, 1'b1, fifo_count_q <= (TW+1)'(trq_pkg::TaskCount))
	`TRQ_ASSERT_IMP(a_free_rng, clk, arst_n, 1'b1, free_count_q <= (NW+1)'(trq_pkg::WaitSlots))
	`TRQ_ASSERT_NXT(a_deq_flag, clk, arst_n, deq_hit, has_q)
endmodule

>>> rtl/task_ready_queue_with_wait_lists_unit.sv
// Top level of the task ready queue with per-dependency wait lists.
// After reset the unit fills the free-node stack and accepts no item until
// that is done. Each item passes accept, memory lookup and result, which
// waits out any output stall; a complete walks its wait list in between,
// a node read and a step per node. One item is in work at a time.
module task_ready_queue_with_wait_lists_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  trq_pkg::in_item_t    in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output trq_pkg::out_item_t   out_item
);
	trq_pkg::cmd_t cmd;
	trq_pkg::sts_t sts;
	logic [1:0] act;

	trq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .action(act),
		.out_busy(out_valid), .sts(sts), .in_stall(in_stall), .cmd(cmd)
	);

	trq_dp u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_item), .cmd(cmd), .sts(sts),
		.act(act), .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);
endmodule
